>>> src/fast12_pkg.sv
// Package for the FAST-12 corner score block: widths, reset values, register indexes.
// No dependencies.
package fast12_pkg;
   localparam int MaxWidthDefault = 2048;
   localparam int PixW = 8;
   localparam int ColBytes = 6;
   localparam int WinRows = 7;
   localparam int WinCols = 7;
   localparam int RowCountW = 12;
   localparam logic [7:0] ThresholdReset = 8'd5;
   localparam logic [11:0] LineWidthReset = 12'd640;
   localparam logic [15:0] RunMask = 16'h0FFF;
   localparam logic [11:0] CsrThreshold = 12'd0;
   localparam logic [11:0] CsrLineWidth = 12'd1;

   // Window taps of the radius-three circle: column offset from the centre, row offset.
   typedef struct packed {
      logic signed [2:0] dx;
      logic signed [2:0] dy;
   } tap_type;

   function automatic tap_type circle_tap(input logic [3:0] t);
      tap_type r;
      case (t)
         4'd0:  r = '{dx: 3'sd0,  dy: -3'sd3};
         4'd1:  r = '{dx: 3'sd1,  dy: -3'sd3};
         4'd2:  r = '{dx: 3'sd2,  dy: -3'sd2};
         4'd3:  r = '{dx: 3'sd3,  dy: -3'sd1};
         4'd4:  r = '{dx: 3'sd3,  dy: 3'sd0};
         4'd5:  r = '{dx: 3'sd3,  dy: 3'sd1};
         4'd6:  r = '{dx: 3'sd2,  dy: 3'sd2};
         4'd7:  r = '{dx: 3'sd1,  dy: 3'sd3};
         4'd8:  r = '{dx: 3'sd0,  dy: 3'sd3};
         4'd9:  r = '{dx: -3'sd1, dy: 3'sd3};
         4'd10: r = '{dx: -3'sd2, dy: 3'sd2};
         4'd11: r = '{dx: -3'sd3, dy: 3'sd1};
         4'd12: r = '{dx: -3'sd3, dy: 3'sd0};
         4'd13: r = '{dx: -3'sd3, dy: -3'sd1};
         4'd14: r = '{dx: -3'sd2, dy: -3'sd2};
         default: r = '{dx: -3'sd1, dy: -3'sd3};
      endcase
      return r;
   endfunction

   // Sideband carried along with each word through the pipeline.
   typedef struct packed {
      logic border;
      logic line_end;
   } side_type;
endpackage

>>> src/fast12_line_store.sv
// Line store: six previous lines per column in one synchronous memory, with the window
// shift register and forwarding for back-to-back accesses to the same column.
// Depends on fast12_pkg.
module fast12_line_store
   import fast12_pkg::*;
#(
   parameter int MaxWidth = MaxWidthDefault,
   localparam int AddrW = $clog2(MaxWidth)
) (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic rd_en,
   input  logic [AddrW-1:0] rd_addr,
   input  logic [PixW-1:0] pixel,
   output logic [WinRows*WinCols*PixW-1:0] window
);
   logic [ColBytes*PixW-1:0] mem [MaxWidth];
   logic [ColBytes*PixW-1:0] rdata_ff;
   logic [AddrW-1:0] addr_ff;
   logic [PixW-1:0] pix_ff;
   logic [ColBytes*PixW-1:0] col;
   logic [WinCols*PixW-1:0] win_ff [WinRows];

   // Read in the accept cycle; the column is registered and consumed when the window next advances.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
         addr_ff <= rd_addr;
         pix_ff <= pixel;
      end
      if (advance) begin
         mem[addr_ff] <= {col[ColBytes*PixW-PixW-1:0], pix_ff};
      end
   end

   // Forward a write that the read of the same column did not see.
   logic hit_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (rd_en) begin
         hit_ff <= advance && (addr_ff == rd_addr);
      end else if (advance) begin
         hit_ff <= 1'b0;
      end
   end

   logic [ColBytes*PixW-1:0] hold_ff;
   always_ff @(posedge clock) begin
      if (rd_en && advance) begin
         hold_ff <= {col[ColBytes*PixW-PixW-1:0], pix_ff};
      end
   end

   assign col = hit_ff ? hold_ff : rdata_ff;

   // Window: each row shifts one pixel left; byte k of the column is line y-1-k.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < WinRows; r++) win_ff[r] <= '0;
      end else if (advance) begin
         for (int r = 0; r < ColBytes; r++) begin
            win_ff[r] <= {win_ff[r][(WinCols-1)*PixW-1:0],
                          col[(ColBytes-1-r)*PixW +: PixW]};
         end
         win_ff[WinRows-1] <= {win_ff[WinRows-1][(WinCols-1)*PixW-1:0], pix_ff};
      end
   end

   always_comb begin
      for (int r = 0; r < WinRows; r++) window[r*WinCols*PixW +: WinCols*PixW] = win_ff[r];
   end
endmodule

>>> src/fast12_score.sv
// Corner test and score over a 7x7 window: registered tap compares, then an adder tree.
// Depends on fast12_pkg.
module fast12_score
   import fast12_pkg::*;
(
   input  logic clock,
   input  logic [WinRows*WinCols*PixW-1:0] window,
   input  logic [PixW-1:0] threshold,
   input  logic en1,
   output logic [PixW-1:0] score
);
   logic [15:0] bright, dark;
   logic [15:0][PixW-3:0] dq;
   logic [PixW-1:0] c;
   logic [PixW:0] hi, lo;

   function automatic logic [PixW-1:0] px(input logic [WinRows*WinCols*PixW-1:0] w,
                                         input logic signed [2:0] dx,
                                         input logic signed [2:0] dy);
      logic [2:0] r, s;
      r = 3'(3 + dy);
      s = 3'(3 - dx);
      return w[(int'(r)*WinCols + int'(s))*PixW +: PixW];
   endfunction

   function automatic logic run12(input logic [15:0] b);
      logic f;
      logic [15:0] m;
      f = 1'b0;
      for (int s = 0; s < 16; s++) begin
         m = (RunMask << s) | (RunMask >> (16 - s));
         if ((b & m) == m) f = 1'b1;
      end
      return f;
   endfunction

   // Stage one: tap compares and quarter differences.
   always_comb begin
      tap_type tp;
      logic [PixW-1:0] p;
      c = px(window, 3'sd0, 3'sd0);
      hi = {1'b0, c} + {1'b0, threshold};
      if (hi > 9'd255) hi = 9'd255;
      lo = (c > threshold) ? {1'b0, c - threshold} : 9'd0;
      for (int t = 0; t < 16; t++) begin
         tp = circle_tap(4'(t));
         p = px(window, tp.dx, tp.dy);
         bright[t] = {1'b0, p} > hi;
         dark[t] = {1'b0, p} < lo;
         dq[t] = (PixW-2)'(((p > c) ? p - c : c - p) >> 2);
      end
   end

   logic corner_ff;
   logic [15:0][PixW-3:0] dq_ff;
   logic [PixW+3:0] sum;

   always_ff @(posedge clock) begin
      if (en1) begin
         corner_ff <= run12(bright) || run12(dark);
         dq_ff <= dq;
      end
   end

   // Stage two: adder tree and saturation, presented with the result word.
   always_comb begin
      sum = '0;
      for (int t = 0; t < 16; t++) sum = sum + (PixW+4)'(dq_ff[t]);
   end

   assign score = !corner_ff ? '0 : (sum > 12'd255 ? 8'd255 : sum[PixW-1:0]);
endmodule

>>> src/fast12_corner_score.sv
// FAST-12 corner score over a raster pixel stream; one result word per input word.
// Each pixel passes the column read register, the window and the score register.
// Throughput: one word per cycle unless rsp_ready stalls; memory access is per word.
// Reset clears counters, window and registers; the line memory is not cleared.
module fast12_corner_score
   import fast12_pkg::*;
#(
   parameter int MaxWidth = MaxWidthDefault,
   localparam int AddrW = $clog2(MaxWidth)
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [7:0] req_pixel,
   input  logic req_frame_start,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [7:0] rsp_score,
   output logic rsp_border,
   output logic rsp_line_end,
   input  logic csr_write,
   input  logic [11:0] csr_index,
   input  logic [11:0] csr_data
);
   logic [7:0] threshold_ff;
   logic [11:0] line_width_ff;
   logic [AddrW:0] col_ff, col_in, x;
   logic [RowCountW-1:0] row_ff, row_in, y;
   logic [AddrW:0] wlast;
   logic v1_ff, v2_ff, v3_ff, en, en2, en3;
   side_type s1_ff, s2_ff, s3_ff, s0;
   logic [WinRows*WinCols*PixW-1:0] window;

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= ThresholdReset;
         line_width_ff <= LineWidthReset;
      end else if (csr_write) begin
         case (csr_index)
            CsrThreshold: threshold_ff <= csr_data[7:0];
            CsrLineWidth: line_width_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Pipeline advances when the last stage is free.
   assign en3 = !v3_ff || rsp_ready;
   assign en2 = en3;
   assign en = en3;
   assign req_ready = en;

   always_comb begin
      if (line_width_ff < 12'd7) wlast = (AddrW+1)'(6);
      else if (int'(line_width_ff) > MaxWidth) wlast = (AddrW+1)'(MaxWidth - 1);
      else wlast = (AddrW+1)'(line_width_ff - 12'd1);
      x = req_frame_start ? '0 : col_ff;
      y = req_frame_start ? '0 : row_ff;
      if (x > (AddrW+1)'(MaxWidth - 1)) x = (AddrW+1)'(MaxWidth - 1);
      s0.border = (x < (AddrW+1)'(6)) || (y < RowCountW'(6));
      s0.line_end = (x == (AddrW+1)'(2));
      if ((req_frame_start ? '0 : col_ff) >= wlast) begin
         col_in = '0;
         row_in = (y == '1) ? y : y + 1'b1;
      end else begin
         col_in = (req_frame_start ? '0 : col_ff) + 1'b1;
         row_in = y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         if (req_valid) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (en) begin
         s1_ff <= s0;
         s2_ff <= s1_ff;
         s3_ff <= s2_ff;
      end
   end

   fast12_line_store #(.MaxWidth(MaxWidth)) u_store (
      .clock(clock), .reset(reset),
      .advance(en && v1_ff), .rd_en(en && req_valid),
      .rd_addr(x[AddrW-1:0]), .pixel(req_pixel), .window(window)
   );

   logic [7:0] score;
   fast12_score u_score (
      .clock(clock), .window(window), .threshold(threshold_ff),
      .en1(en2 && v2_ff), .score(score)
   );

   assign rsp_valid = v3_ff;
   assign rsp_score = s3_ff.border ? 8'd0 : score;
   assign rsp_border = s3_ff.border;
   assign rsp_line_end = s3_ff.line_end;
endmodule
